// ===== hw/rtl/aacr_pkg.sv =====
// Package for the antialiased filled circle rasteriser.
// Holds shared widths, the job struct passed from front to back, and codes.
package aacr_pkg;
  localparam int unsigned COORD_BITS = 8;
  localparam int unsigned PIX_BITS = 10;
  localparam int unsigned RAD_BITS = 11;
  localparam int unsigned SQ_BITS = 26;  // (i*i+j*j)*256 for i,j < 128
  localparam int unsigned ROOT_BITS = 13;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {
    KindIdle = 2'd0,
    KindNone = 2'd1,
    KindFull = 2'd2,
    KindEdge = 2'd3
  } kind_e;

  // One classified step handed to the back end.
  typedef struct packed {
    kind_e                 kind;
    logic                  done;
    logic [7:0]            i;
    logic [7:0]            j;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [RAD_BITS-1:0]   radius;
    logic [SQ_BITS-1:0]    s;
    logic [23:0]           colour;
  } job_t;
endpackage

// ===== hw/rtl/antialiased_filled_circle_raster.sv =====
// Top level of the antialiased filled circle rasteriser.
// Depends on aacr_pkg, aacr_front, aacr_queue and aacr_back.
//
// Input words arrive through push/full. A start word (action 0) latches centre,
// radius (Q7.4) and colour and yields no result. A step word (action 1) visits the
// next octant point and yields either eight mirrored pixel words or one word with
// write_valid low; the final word of a step carries last_in_run.
// Results leave through empty/pop; the oldest word sits on the ports while
// empty is low and stays put while the receiver does not pop.
// Structure: two front stages classify a point, a two-entry queue follows, then the
// back end. A full-colour point then emits its eight words; an edge point first adds
// a two-bit-per-cycle square root and a blend step. The back end's serial root and
// word emission set the rate.
// Words are still taken while the back end works, until queue and front stages fill.
// Reset clears the scan to idle and empties queue and output register.
module antialiased_filled_circle_raster import aacr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                action_i,
  input  logic [7:0]          center_x_i,
  input  logic [7:0]          center_y_i,
  input  logic [RAD_BITS-1:0] radius_q_i,
  input  logic [7:0]          red_in_i,
  input  logic [7:0]          green_in_i,
  input  logic [7:0]          blue_in_i,
  output logic                empty,
  input  logic                pop,
  output logic                write_valid_o,
  output logic [PIX_BITS-1:0] pixel_first_o,
  output logic [PIX_BITS-1:0] pixel_second_o,
  output logic [7:0]          red_out_o,
  output logic [7:0]          green_out_o,
  output logic [7:0]          blue_out_o,
  output logic                last_in_run_o,
  output logic                scan_done_o
);
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  aacr_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .action_i, .center_x_i,
    .center_y_i, .radius_q_i, .red_in_i, .green_in_i, .blue_in_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  aacr_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_ready_o(f_ready), .in_job_i(f_job),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_job_o(b_job)
  );

  aacr_back u_back (
    .clk_i, .rst_ni, .job_valid_i(b_valid), .job_ready_o(b_ready), .job_i(b_job),
    .empty_o(empty), .pop_i(pop), .write_valid_o, .pixel_first_o, .pixel_second_o,
    .red_out_o, .green_out_o, .blue_out_o, .last_in_run_o, .scan_done_o
  );
endmodule

// ===== hw/rtl/aacr_front.sv =====
// Front end: latches start words, walks the octant scan and classifies each point.
// Depends on aacr_pkg.
module aacr_front import aacr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic                  action_i,
  input  logic [7:0]            center_x_i,
  input  logic [7:0]            center_y_i,
  input  logic [RAD_BITS-1:0]   radius_q_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  job_valid_o,
  input  logic                  job_ready_i,
  output job_t                  job_o
);
  logic [7:0] row_q, col_q, row_d, col_d;
  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [RAD_BITS-1:0] rad_q;
  logic [23:0] col_rgb_q;
  logic active_q, active_d;
  // Two stages: multiply i*i and j*j, then sum and compare.
  logic       s1_v_q;
  job_t       s1_q;
  logic [15:0] ii_q, jj_q;
  logic       s2_v_q;
  job_t       s2_q;
  logic       accept, step, s2_free, s1_free;
  logic [SQ_BITS-1:0] s_sum;
  logic [2*RAD_BITS-1:0] rr, rf;
  logic [RAD_BITS-1:0] rm;

  assign s2_free = !s2_v_q || job_ready_i;
  assign s1_free = !s1_v_q || s2_free;
  assign full_o = !s1_free;
  assign accept = push_i && !full_o;
  assign step = accept && action_i;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    active_d = active_q;
    if (col_q + 8'd1 > row_q) begin
      col_d = '0;
      row_d = row_q + 8'd1;
      if ({row_d, 4'b0} >= {1'b0, rad_q}) active_d = 1'b0;
    end else begin
      col_d = col_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; active_q <= 1'b0;
      cx_q <= '0; cy_q <= '0; rad_q <= '0; col_rgb_q <= '0;
      s1_v_q <= 1'b0; s2_v_q <= 1'b0;
    end else begin
      if (accept && !action_i) begin
        cx_q <= center_x_i[COORD_BITS-1:0];
        cy_q <= center_y_i[COORD_BITS-1:0];
        rad_q <= radius_q_i;
        col_rgb_q <= {red_in_i, green_in_i, blue_in_i};
        row_q <= '0; col_q <= '0;
        active_q <= radius_q_i != '0;
      end else if (step && active_q) begin
        row_q <= row_d; col_q <= col_d; active_q <= active_d;
      end
      if (s1_free) s1_v_q <= step;
      if (s2_free) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && step) begin
      s1_q.kind <= active_q ? KindNone : KindIdle;
      s1_q.done <= active_q ? !active_d : 1'b1;
      s1_q.i <= row_q; s1_q.j <= col_q;
      s1_q.cx <= cx_q; s1_q.cy <= cy_q;
      s1_q.radius <= rad_q; s1_q.colour <= col_rgb_q;
      s1_q.s <= '0;
      ii_q <= row_q * row_q;
      jj_q <= col_q * col_q;
    end
    if (s2_free && s1_v_q) begin
      s2_q <= s1_q;
      s2_q.s <= s_sum;
      if (s1_q.kind != KindIdle) begin
        if ((s1_q.radius >= RAD_BITS'(16)) && ({2'b0, s_sum} <= {6'b0, rf}))
          s2_q.kind <= KindFull;
        else if ({2'b0, s_sum} < {6'b0, rr}) s2_q.kind <= KindEdge;
        else s2_q.kind <= KindNone;
      end
    end
  end

  assign s_sum = SQ_BITS'({({1'b0, ii_q} + {1'b0, jj_q}), 8'b0});
  assign rm = s1_q.radius - RAD_BITS'(16);
  assign rr = s1_q.radius * s1_q.radius;
  assign rf = rm * rm;

  assign job_valid_o = s2_v_q;
  assign job_o = s2_q;
endmodule

// ===== hw/rtl/aacr_queue.sv =====
// Short job queue between the front and back ends.
// Depends on aacr_pkg.
module aacr_queue import aacr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_job_o
);
  job_t mem_q [QDEPTH];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign in_ready_o = cnt_q != 2'(QDEPTH);
  assign out_valid_o = cnt_q != '0;
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;
  assign out_job_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_job_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDEPTH)) else $error("queue count overflow");
  a_rd_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd && !wr |=> rp_q != $past(rp_q) && cnt_q == $past(cnt_q) - 2'd1)
    else $error("queue read bookkeeping");
  a_wr_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue write bookkeeping");
`endif
endmodule

// ===== hw/rtl/aacr_back.sv =====
// Back end: square root for edge points, colour blend and eight mirrored words.
// Depends on aacr_pkg.
module aacr_back import aacr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  job_t                job_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic                write_valid_o,
  output logic [PIX_BITS-1:0] pixel_first_o,
  output logic [PIX_BITS-1:0] pixel_second_o,
  output logic [7:0]          red_out_o,
  output logic [7:0]          green_out_o,
  output logic [7:0]          blue_out_o,
  output logic                last_in_run_o,
  output logic                scan_done_o
);
  typedef enum logic [1:0] {StIdle, StRoot, StBlend, StEmit} back_state_e;
  back_state_e st_q, st_d;
  job_t job_q;
  logic [SQ_BITS-1:0] v_q;
  logic [SQ_BITS-1:0] res_q, bit_q;
  logic [7:0] sr_q, sg_q, sb_q;
  logic [2:0] k_q;
  logic load, root_end, emit_adv;
  logic [SQ_BITS-1:0] trial;
  logic [RAD_BITS-1:0] w_full;
  logic [4:0] w;
  logic [12:0] pr, pg, pb;
  logic signed [PIX_BITS-1:0] xs, ys, is_, js, pf, ps;

  // Output register, held until popped.
  logic out_v_q;
  assign empty_o = !out_v_q;

  assign trial = res_q + bit_q;
  assign root_end = bit_q == '0;
  assign load = (st_q == StIdle) && job_valid_i;
  assign job_ready_o = st_q == StIdle;
  assign emit_adv = (st_q == StEmit) && (!out_v_q || pop_i);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (job_valid_i) st_d = (job_i.kind == KindEdge) ? StRoot : StEmit;
      StRoot:  if (root_end) st_d = StBlend;
      StBlend: st_d = StEmit;
      StEmit:  if (emit_adv && ((k_q == 3'd7) || job_q.kind == KindNone
                 || job_q.kind == KindIdle)) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // Edge weight from radius minus root, clamped to 16.
  always_comb begin
    w_full = job_q.radius - res_q[RAD_BITS-1:0];
    if (res_q[RAD_BITS-1:0] >= job_q.radius) w = '0;
    else if (w_full > RAD_BITS'(16)) w = 5'd16;
    else w = w_full[4:0];
    pr = job_q.colour[23:16] * w;
    pg = job_q.colour[15:8] * w;
    pb = job_q.colour[7:0] * w;
  end

  always_comb begin
    xs = PIX_BITS'(job_q.cx);
    ys = PIX_BITS'(job_q.cy);
    is_ = PIX_BITS'(job_q.i);
    js = PIX_BITS'(job_q.j);
    pf = '0; ps = '0;
    if (job_q.kind == KindFull) begin
      unique case (k_q)
        3'd0: begin pf = ys - js; ps = xs + is_; end
        3'd1: begin pf = ys + js; ps = xs + is_; end
        3'd2: begin pf = ys + js; ps = xs - is_; end
        3'd3: begin pf = ys - js; ps = xs - is_; end
        3'd4: begin pf = ys - is_; ps = xs - js; end
        3'd5: begin pf = ys - is_; ps = xs + js; end
        3'd6: begin pf = ys + is_; ps = xs + js; end
        default: begin pf = ys + is_; ps = xs - js; end
      endcase
    end else begin
      unique case (k_q)
        3'd0: begin pf = ys - js; ps = xs + is_; end
        3'd1: begin pf = ys + js; ps = xs + is_; end
        3'd2: begin pf = ys + js; ps = xs - is_; end
        3'd3: begin pf = ys - js; ps = xs - is_; end
        3'd4: begin pf = ys - is_; ps = xs + js; end
        3'd5: begin pf = ys + is_; ps = xs + js; end
        3'd6: begin pf = ys + is_; ps = xs - js; end
        default: begin pf = ys - is_; ps = xs - js; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; out_v_q <= 1'b0; k_q <= '0;
    end else begin
      st_q <= st_d;
      if (load) k_q <= '0;
      else if (emit_adv) k_q <= k_q + 3'd1;
      if (emit_adv) out_v_q <= 1'b1;
      else if (pop_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
      v_q <= job_i.s;
      res_q <= '0;
      bit_q <= SQ_BITS'(1) << (SQ_BITS - 2);
      sr_q <= job_i.colour[23:16];
      sg_q <= job_i.colour[15:8];
      sb_q <= job_i.colour[7:0];
    end
    if (st_q == StRoot) begin
      if (bit_q > v_q && res_q == '0) begin
        bit_q <= bit_q >> 2;
      end else if (!root_end) begin
        if (v_q >= trial) begin
          v_q <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
    if (st_q == StBlend) begin
      sr_q <= pr[11:4]; sg_q <= pg[11:4]; sb_q <= pb[11:4];
    end
    if (emit_adv) begin
      if (job_q.kind == KindFull || job_q.kind == KindEdge) begin
        write_valid_o <= 1'b1;
        pixel_first_o <= pf; pixel_second_o <= ps;
        red_out_o <= sr_q; green_out_o <= sg_q; blue_out_o <= sb_q;
        last_in_run_o <= k_q == 3'd7;
      end else begin
        write_valid_o <= 1'b0;
        pixel_first_o <= '0; pixel_second_o <= '0;
        red_out_o <= '0; green_out_o <= '0; blue_out_o <= '0;
        last_in_run_o <= 1'b1;
      end
      scan_done_o <= job_q.done;
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !pop_i |=> out_v_q && $stable(pixel_first_o))
    else $error("result word changed while stalled");
  a_root_only_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRoot |-> job_q.kind == KindEdge) else $error("root on non-edge job");
  a_emit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StEmit && k_q != 3'd0 |-> job_q.kind == KindFull || job_q.kind == KindEdge)
    else $error("multiple words for a no-write job");
`endif
endmodule
